// ===== sv/parallel_port_scsi_initiator_top_macros.svh =====
// assertion macros for the parallel port scsi initiator
`ifndef PARALLEL_PORT_SCSI_INITIATOR_TOP_MACROS_SVH
`define PARALLEL_PORT_SCSI_INITIATOR_TOP_MACROS_SVH

`ifndef SYNTH
`define PPSI_ASSERT_SAME(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("same-cycle check failed");
`define PPSI_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define PPSI_ASSERT_SAME(label, a, b)
`define PPSI_ASSERT_NEXT(label, a, b)
`endif

`endif

// ===== sv/ppsi_pkg.sv =====
package ppsi_pkg;

   localparam logic [3:0] MAX_CMD_BYTES = 4'd15;

   typedef struct packed {
      logic [1:0] mode;
      logic [2:0] target;
      logic [3:0] command_length;
      logic [7:0] host_byte;
      logic [3:0] status_nibble;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] value;
      logic [1:0] error_kind;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_CMD    = 2'd1,
      MODE_DATA   = 2'd2,
      MODE_SAMPLE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ACT_DATA      = 3'd0,
      ACT_CTRL      = 3'd1,
      ACT_SAMPLE    = 3'd2,
      ACT_NEED_CMD  = 3'd3,
      ACT_NEED_DATA = 3'd4,
      ACT_BYTE_IN   = 3'd5,
      ACT_FINISHED  = 3'd6
   } act_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_SEL_TIMER  = 2'd1,
      ERR_RDY_TIMER  = 2'd2,
      ERR_BAD_PHASE  = 2'd3
   } err_type;

   typedef enum logic [0:0] {
      CSR_INITIATOR_ID  = 1'd0,
      CSR_TIMEOUT_LIMIT = 1'd1
   } csr_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SELECT    = 3'd1,
      PH_CMD_READY = 3'd2,
      PH_CMD_BYTE  = 3'd3,
      PH_BUS_WAIT  = 3'd4,
      PH_DATA_OUT  = 3'd5,
      PH_NIB_HI    = 3'd6,
      PH_NIB_LO    = 3'd7
   } phase_type;

   typedef enum logic [3:0] {
      RUN_START    = 4'd0,
      RUN_BYTE_OUT = 4'd1,
      RUN_SAMPLE   = 4'd2,
      RUN_FAIL     = 4'd3,
      RUN_SEL_OK   = 4'd4,
      RUN_NEED_CMD = 4'd5,
      RUN_NEED_DAT = 4'd6,
      RUN_NIB_HI   = 4'd7,
      RUN_NIB_LO   = 4'd8,
      RUN_BYTE_IN  = 4'd9,
      RUN_DISC     = 4'd10
   } run_kind_type;

   typedef enum logic [1:0] {
      SRC_CONST = 2'd0,
      SRC_ARG_A = 2'd1,
      SRC_ARG_B = 2'd2
   } src_type;

   typedef struct packed {
      run_kind_type kind;
      logic [7:0]   arg_a;
      logic [7:0]   arg_b;
      err_type      err;
   } run_type;

   typedef struct packed {
      act_type    act;
      src_type    src;
      logic [7:0] val;
   } entry_type;

   function automatic entry_type mk(act_type act, src_type src, logic [7:0] val);
      entry_type e;
      e.act = act;
      e.src = src;
      e.val = val;
      return e;
   endfunction

   function automatic logic [4:0] run_len(run_kind_type kind);
      case (kind)
         RUN_START:    return 5'd26;
         RUN_BYTE_OUT: return 5'd4;
         RUN_SEL_OK:   return 5'd2;
         RUN_NIB_HI:   return 5'd2;
         RUN_NIB_LO:   return 5'd2;
         RUN_BYTE_IN:  return 5'd3;
         RUN_DISC:     return 5'd23;
         default:      return 5'd1;
      endcase
   endfunction

   // connect train, then selection
   function automatic entry_type start_entry(logic [4:0] idx);
      case (idx)
         5'd0:  return mk(ACT_DATA, SRC_CONST, 8'h00);
         5'd1:  return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd2:  return mk(ACT_CTRL, SRC_CONST, 8'h06);
         5'd3:  return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd4:  return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd5:  return mk(ACT_DATA, SRC_CONST, 8'h3C);
         5'd6:  return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd7:  return mk(ACT_CTRL, SRC_CONST, 8'h06);
         5'd8:  return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd9:  return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd10: return mk(ACT_DATA, SRC_CONST, 8'h20);
         5'd11: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd12: return mk(ACT_CTRL, SRC_CONST, 8'h06);
         5'd13: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd14: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd15: return mk(ACT_DATA, SRC_CONST, 8'h8F);
         5'd16: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd17: return mk(ACT_CTRL, SRC_CONST, 8'h06);
         5'd18: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd19: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd20: return mk(ACT_DATA, SRC_ARG_A, 8'h00);
         5'd21: return mk(ACT_CTRL, SRC_CONST, 8'h0E);
         5'd22: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd23: return mk(ACT_DATA, SRC_ARG_B, 8'h00);
         5'd24: return mk(ACT_CTRL, SRC_CONST, 8'h08);
         default: return mk(ACT_SAMPLE, SRC_CONST, 8'h00);
      endcase
   endfunction

   // status byte handshake, disconnect train, final status
   function automatic entry_type disc_entry(logic [4:0] idx);
      case (idx)
         5'd0:  return mk(ACT_CTRL, SRC_CONST, 8'h0E);
         5'd1:  return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd2:  return mk(ACT_DATA, SRC_CONST, 8'h00);
         5'd3:  return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd4:  return mk(ACT_CTRL, SRC_CONST, 8'h0E);
         5'd5:  return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd6:  return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd7:  return mk(ACT_DATA, SRC_CONST, 8'h3C);
         5'd8:  return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd9:  return mk(ACT_CTRL, SRC_CONST, 8'h0E);
         5'd10: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd11: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd12: return mk(ACT_DATA, SRC_CONST, 8'h20);
         5'd13: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd14: return mk(ACT_CTRL, SRC_CONST, 8'h0E);
         5'd15: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd16: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd17: return mk(ACT_DATA, SRC_CONST, 8'h0F);
         5'd18: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         5'd19: return mk(ACT_CTRL, SRC_CONST, 8'h0E);
         5'd20: return mk(ACT_CTRL, SRC_CONST, 8'h04);
         5'd21: return mk(ACT_CTRL, SRC_CONST, 8'h0C);
         default: return mk(ACT_FINISHED, SRC_ARG_A, 8'h00);
      endcase
   endfunction

   function automatic entry_type script_entry(run_kind_type kind, logic [4:0] idx);
      case (kind)
         RUN_START: return start_entry(idx);
         RUN_DISC:  return disc_entry(idx);
         RUN_BYTE_OUT: begin
            case (idx)
               5'd0:    return mk(ACT_DATA, SRC_ARG_A, 8'h00);
               5'd1:    return mk(ACT_CTRL, SRC_CONST, 8'h0E);
               5'd2:    return mk(ACT_CTRL, SRC_CONST, 8'h0C);
               default: return mk(ACT_SAMPLE, SRC_CONST, 8'h00);
            endcase
         end
         RUN_FAIL:     return mk(ACT_FINISHED, SRC_CONST, 8'hFF);
         RUN_NEED_CMD: return mk(ACT_NEED_CMD, SRC_CONST, 8'h00);
         RUN_NEED_DAT: return mk(ACT_NEED_DATA, SRC_CONST, 8'h00);
         RUN_SEL_OK:
            return (idx == 5'd0) ? mk(ACT_CTRL, SRC_CONST, 8'h0C)
                                 : mk(ACT_SAMPLE, SRC_CONST, 8'h00);
         RUN_NIB_HI:
            return (idx == 5'd0) ? mk(ACT_CTRL, SRC_CONST, 8'h04)
                                 : mk(ACT_SAMPLE, SRC_CONST, 8'h00);
         RUN_NIB_LO:
            return (idx == 5'd0) ? mk(ACT_CTRL, SRC_CONST, 8'h06)
                                 : mk(ACT_SAMPLE, SRC_CONST, 8'h00);
         RUN_BYTE_IN: begin
            case (idx)
               5'd0:    return mk(ACT_BYTE_IN, SRC_ARG_A, 8'h00);
               5'd1:    return mk(ACT_CTRL, SRC_CONST, 8'h0C);
               default: return mk(ACT_SAMPLE, SRC_CONST, 8'h00);
            endcase
         end
         default: return mk(ACT_SAMPLE, SRC_CONST, 8'h00);
      endcase
   endfunction

endpackage

// ===== sv/parallel_port_scsi_initiator_top.sv =====
// parallel port scsi initiator: each request transfer is decoded combinationally into a run
// of port actions, held in a one-deep run buffer, and played out by the emitter at one
// response transfer per cycle while rsp_stall is low, through a registered output. a start
// yields 26 responses, the status-byte read with disconnect 23, the rest 1 to 4, and some
// none. requests are taken back to back while the run buffer is free, so a request is
// accepted every cycle for runs of one response while the response side does not stall;
// otherwise a request waits until the single-response-per-cycle emitter takes the
// buffered run. timeout_limit and initiator_id take effect for requests transferred after the write.
`include "parallel_port_scsi_initiator_top_macros.svh"

module parallel_port_scsi_initiator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  ppsi_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ppsi_pkg::rsp_type  rsp_data
);

   logic              desc_valid;
   logic              desc_take;
   ppsi_pkg::run_type desc;

   logic              rsp_err;
   logic              rsp_fail;
   logic              start_xfer;
   logic              start_run;

   ppsi_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .desc_take  (desc_take),
      .desc_valid (desc_valid),
      .desc       (desc)
   );

   ppsi_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_take  (desc_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_err    = rsp_valid && rsp_data.error_kind != ppsi_pkg::ERR_NONE;
   assign rsp_fail   = rsp_data.action == ppsi_pkg::ACT_FINISHED && rsp_data.value == 8'hFF;
   assign start_xfer = req_valid && !req_stall && req_data.mode == ppsi_pkg::MODE_START;
   assign start_run  = desc_valid && desc.kind == ppsi_pkg::RUN_START;

   // error codes only on an error finish
   `PPSI_ASSERT_SAME(a_err_finish, rsp_err, rsp_fail)
   // a buffered run is never dropped
   `PPSI_ASSERT_NEXT(a_run_kept, desc_valid && !desc_take, desc_valid)
   // a start transfer always queues a run
   `PPSI_ASSERT_NEXT(a_start_run, start_xfer, start_run)

endmodule

// ===== sv/ppsi_engine.sv =====
module ppsi_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   input  ppsi_pkg::req_type  req_data,
   output logic               req_stall,
   input  logic               desc_take,
   output logic               desc_valid,
   output ppsi_pkg::run_type  desc
);

   ppsi_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         wait_ff, wait_in;
   logic [3:0]          bytes_ff, bytes_in;
   logic [3:0]          high_ff, high_in;
   logic                rstat_ff, rstat_in;
   logic [2:0]          init_id_ff;
   logic [15:0]         limit_ff;
   logic                desc_valid_ff, desc_valid_in;
   ppsi_pkg::run_type   desc_ff, desc_in;

   logic       accept;
   logic       emit;
   logic       ready;
   logic       expired;
   logic [3:0] bytes_dec;
   ppsi_pkg::run_type run;

   assign req_stall  = desc_valid_ff && !desc_take;
   assign accept     = req_valid && !req_stall;
   assign ready      = req_data.status_nibble[3];
   assign expired    = wait_ff >= limit_ff;
   assign bytes_dec  = (bytes_ff != 4'd0) ? bytes_ff - 4'd1 : 4'd0;
   assign desc_valid = desc_valid_ff;
   assign desc       = desc_ff;

   always_comb begin
      phase_in  = phase_ff;
      wait_in   = wait_ff;
      bytes_in  = bytes_ff;
      high_in   = high_ff;
      rstat_in  = rstat_ff;
      emit      = 1'b0;
      run.kind  = ppsi_pkg::RUN_SAMPLE;
      run.arg_a = req_data.host_byte;
      run.arg_b = 8'h00;
      run.err   = ppsi_pkg::ERR_NONE;
      case (ppsi_pkg::mode_type'(req_data.mode))
         ppsi_pkg::MODE_START: begin
            emit      = 1'b1;
            run.kind  = ppsi_pkg::RUN_START;
            run.arg_a = 8'h01 << req_data.target;
            run.arg_b = 8'h01 << init_id_ff;
            bytes_in  = (req_data.command_length > ppsi_pkg::MAX_CMD_BYTES)
                        ? ppsi_pkg::MAX_CMD_BYTES : req_data.command_length;
            wait_in   = 16'd0;
            rstat_in  = 1'b0;
            phase_in  = ppsi_pkg::PH_SELECT;
         end
         ppsi_pkg::MODE_CMD: begin
            if (phase_ff == ppsi_pkg::PH_CMD_BYTE) begin
               emit     = 1'b1;
               run.kind = ppsi_pkg::RUN_BYTE_OUT;
               bytes_in = bytes_dec;
               phase_in = (bytes_dec != 4'd0) ? ppsi_pkg::PH_CMD_READY
                                              : ppsi_pkg::PH_BUS_WAIT;
               wait_in  = 16'd0;
            end
         end
         ppsi_pkg::MODE_DATA: begin
            if (phase_ff == ppsi_pkg::PH_DATA_OUT) begin
               emit     = 1'b1;
               run.kind = ppsi_pkg::RUN_BYTE_OUT;
               phase_in = ppsi_pkg::PH_BUS_WAIT;
               wait_in  = 16'd0;
            end
         end
         default: begin
            case (phase_ff)
               ppsi_pkg::PH_SELECT: begin
                  emit = 1'b1;
                  if (req_data.status_nibble == 4'd0) begin
                     if (expired) begin
                        run.kind = ppsi_pkg::RUN_FAIL;
                        run.err  = ppsi_pkg::ERR_SEL_TIMER;
                        phase_in = ppsi_pkg::PH_IDLE;
                     end else begin
                        wait_in = wait_ff + 16'd1;
                     end
                  end else begin
                     run.kind = ppsi_pkg::RUN_SEL_OK;
                     phase_in = (bytes_ff != 4'd0) ? ppsi_pkg::PH_CMD_READY
                                                   : ppsi_pkg::PH_BUS_WAIT;
                     wait_in  = 16'd0;
                  end
               end
               ppsi_pkg::PH_CMD_READY: begin
                  emit = 1'b1;
                  if (!ready) begin
                     if (expired) begin
                        run.kind = ppsi_pkg::RUN_FAIL;
                        run.err  = ppsi_pkg::ERR_RDY_TIMER;
                        phase_in = ppsi_pkg::PH_IDLE;
                     end else begin
                        wait_in = wait_ff + 16'd1;
                     end
                  end else begin
                     run.kind = ppsi_pkg::RUN_NEED_CMD;
                     phase_in = ppsi_pkg::PH_CMD_BYTE;
                  end
               end
               ppsi_pkg::PH_BUS_WAIT: begin
                  emit = 1'b1;
                  if (!ready) begin
                     if (expired) begin
                        run.kind = ppsi_pkg::RUN_FAIL;
                        run.err  = ppsi_pkg::ERR_RDY_TIMER;
                        phase_in = ppsi_pkg::PH_IDLE;
                     end else begin
                        wait_in = wait_ff + 16'd1;
                     end
                  end else if (req_data.status_nibble == 4'hC) begin
                     run.kind = ppsi_pkg::RUN_NEED_DAT;
                     phase_in = ppsi_pkg::PH_DATA_OUT;
                  end else if (req_data.status_nibble == 4'hD ||
                               req_data.status_nibble == 4'hF) begin
                     run.kind = ppsi_pkg::RUN_NIB_HI;
                     rstat_in = req_data.status_nibble == 4'hF;
                     phase_in = ppsi_pkg::PH_NIB_HI;
                  end else begin
                     run.kind = ppsi_pkg::RUN_FAIL;
                     run.err  = ppsi_pkg::ERR_BAD_PHASE;
                     phase_in = ppsi_pkg::PH_IDLE;
                  end
               end
               ppsi_pkg::PH_NIB_HI: begin
                  emit     = 1'b1;
                  run.kind = ppsi_pkg::RUN_NIB_LO;
                  high_in  = req_data.status_nibble;
                  phase_in = ppsi_pkg::PH_NIB_LO;
               end
               ppsi_pkg::PH_NIB_LO: begin
                  emit      = 1'b1;
                  run.arg_a = {high_ff, req_data.status_nibble};
                  if (!rstat_ff) begin
                     run.kind = ppsi_pkg::RUN_BYTE_IN;
                     phase_in = ppsi_pkg::PH_BUS_WAIT;
                     wait_in  = 16'd0;
                  end else begin
                     run.kind = ppsi_pkg::RUN_DISC;
                     phase_in = ppsi_pkg::PH_IDLE;
                  end
               end
               default: emit = 1'b0;
            endcase
         end
      endcase
   end

   always_comb begin
      desc_valid_in = desc_valid_ff && !desc_take;
      desc_in       = desc_ff;
      if (accept && emit) begin
         desc_valid_in = 1'b1;
         desc_in       = run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ppsi_pkg::PH_IDLE;
         wait_ff       <= 16'd0;
         bytes_ff      <= 4'd0;
         high_ff       <= 4'd0;
         rstat_ff      <= 1'b0;
         init_id_ff    <= 3'd7;
         limit_ff      <= 16'd50000;
         desc_valid_ff <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            wait_ff  <= wait_in;
            bytes_ff <= bytes_in;
            high_ff  <= high_in;
            rstat_ff <= rstat_in;
         end
         if (csr_write) begin
            case (ppsi_pkg::csr_type'(csr_index))
               ppsi_pkg::CSR_INITIATOR_ID:  init_id_ff <= csr_wdata[2:0];
               ppsi_pkg::CSR_TIMEOUT_LIMIT: limit_ff   <= csr_wdata;
               default:                     limit_ff   <= limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

endmodule

// ===== sv/ppsi_emitter.sv =====
module ppsi_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               desc_valid,
   input  ppsi_pkg::run_type  desc,
   output logic               desc_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ppsi_pkg::rsp_type  rsp_data
);

   logic                act_valid_ff, act_valid_in;
   ppsi_pkg::run_type   act_ff, act_in;
   logic [4:0]          idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ppsi_pkg::rsp_type   rsp_ff, rsp_in;

   ppsi_pkg::entry_type entry;
   logic                out_free;
   logic                adv;
   logic                is_last;
   logic [7:0]          value;

   assign entry     = ppsi_pkg::script_entry(act_ff.kind, idx_ff);
   assign is_last   = idx_ff == ppsi_pkg::run_len(act_ff.kind) - 5'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign adv       = act_valid_ff && out_free;
   assign desc_take = !act_valid_ff || (adv && is_last);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (entry.src)
         ppsi_pkg::SRC_ARG_A: value = act_ff.arg_a;
         ppsi_pkg::SRC_ARG_B: value = act_ff.arg_b;
         default:             value = entry.val;
      endcase
   end

   always_comb begin
      act_valid_in = act_valid_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      if (desc_take) begin
         act_valid_in = desc_valid;
         act_in       = desc;
         idx_in       = 5'd0;
      end else if (adv) begin
         idx_in = idx_ff + 5'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !out_free;
      rsp_in       = rsp_ff;
      if (adv) begin
         rsp_valid_in      = 1'b1;
         rsp_in.action     = entry.act;
         rsp_in.value      = value;
         rsp_in.error_kind = (entry.act == ppsi_pkg::ACT_FINISHED) ? act_ff.err
                                                                    : ppsi_pkg::ERR_NONE;
         rsp_in.last       = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 5'd0;
      end else begin
         act_valid_ff <= act_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ppsi_pkg::*;

   localparam int IDLE_SETTLE    = 8;
   localparam int TAIL_CYCLES    = 30;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 300;
   localparam int CFG_EVERY      = 45;

   typedef enum {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      req;
      rsp_type      want;
      logic [2:0]   id;
      logic [15:0]  limit;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;

   // engine copy
   phase_type   eng_phase;
   logic [15:0] eng_wait;
   logic [3:0]  eng_left;
   logic [3:0]  eng_hi;
   logic        eng_status;
   logic [2:0]  cfg_id;
   logic [15:0] cfg_limit;

   rsp_type     run_buf[$];
   rsp_type     pending_actions[$];
   row_type     plan[$];
   rsp_type     oldest;
   bit          quiet;
   int          mismatches = 0;
   int          rsp_hold;
   int          rsp_draw;
   int          idle_cycles = 0;

   parallel_port_scsi_initiator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void put_act(act_type a, logic [7:0] v, err_type e);
      rsp_type t;
      t.action     = a;
      t.value      = v;
      t.error_kind = e;
      t.last       = 1'b0;
      run_buf.push_back(t);
   endfunction

   // data write followed by four control strobes
   function automatic void put_pulse(logic [7:0] v, bit disc);
      put_act(ACT_DATA, v, ERR_NONE);
      put_act(ACT_CTRL, disc ? 8'h0C : 8'h04, ERR_NONE);
      put_act(ACT_CTRL, disc ? 8'h0E : 8'h06, ERR_NONE);
      put_act(ACT_CTRL, 8'h04, ERR_NONE);
      put_act(ACT_CTRL, 8'h0C, ERR_NONE);
   endfunction

   function automatic bit wait_expired();
      if (eng_wait >= cfg_limit) return 1'b1;
      eng_wait = eng_wait + 16'd1;
      return 1'b0;
   endfunction

   function automatic void put_wait(err_type e);
      if (wait_expired()) begin
         eng_phase = PH_IDLE;
         put_act(ACT_FINISHED, 8'hFF, e);
      end else begin
         put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
      end
   endfunction

   function automatic void predict_port_actions(req_type r);
      logic    ready;
      rsp_type t;
      run_buf.delete();
      ready = r.status_nibble[3];
      case (r.mode)
         MODE_START: begin
            put_pulse(8'h00, 1'b0);
            put_pulse(8'h3C, 1'b0);
            put_pulse(8'h20, 1'b0);
            put_pulse(8'h8F, 1'b0);
            put_act(ACT_DATA, 8'd1 << r.target, ERR_NONE);
            put_act(ACT_CTRL, 8'h0E, ERR_NONE);
            put_act(ACT_CTRL, 8'h0C, ERR_NONE);
            put_act(ACT_DATA, 8'd1 << cfg_id, ERR_NONE);
            put_act(ACT_CTRL, 8'h08, ERR_NONE);
            put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
            eng_left   = (r.command_length > MAX_CMD_BYTES) ? MAX_CMD_BYTES : r.command_length;
            eng_wait   = 16'd0;
            eng_status = 1'b0;
            eng_phase  = PH_SELECT;
         end
         MODE_CMD, MODE_DATA: begin
            if ((r.mode == MODE_CMD && eng_phase == PH_CMD_BYTE) ||
                (r.mode == MODE_DATA && eng_phase == PH_DATA_OUT)) begin
               put_act(ACT_DATA, r.host_byte, ERR_NONE);
               put_act(ACT_CTRL, 8'h0E, ERR_NONE);
               put_act(ACT_CTRL, 8'h0C, ERR_NONE);
               put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
               if (r.mode == MODE_CMD) begin
                  if (eng_left != 4'd0) eng_left = eng_left - 4'd1;
                  eng_phase = (eng_left != 4'd0) ? PH_CMD_READY : PH_BUS_WAIT;
               end else begin
                  eng_phase = PH_BUS_WAIT;
               end
               eng_wait = 16'd0;
            end
         end
         default: begin
            case (eng_phase)
               PH_SELECT: begin
                  if (r.status_nibble == 4'h0) begin
                     put_wait(ERR_SEL_TIMER);
                  end else begin
                     put_act(ACT_CTRL, 8'h0C, ERR_NONE);
                     put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
                     eng_phase = (eng_left != 4'd0) ? PH_CMD_READY : PH_BUS_WAIT;
                     eng_wait  = 16'd0;
                  end
               end
               PH_CMD_READY: begin
                  if (!ready) begin
                     put_wait(ERR_RDY_TIMER);
                  end else begin
                     put_act(ACT_NEED_CMD, 8'h00, ERR_NONE);
                     eng_phase = PH_CMD_BYTE;
                  end
               end
               PH_BUS_WAIT: begin
                  if (!ready) begin
                     put_wait(ERR_RDY_TIMER);
                  end else if (r.status_nibble == 4'hC) begin
                     put_act(ACT_NEED_DATA, 8'h00, ERR_NONE);
                     eng_phase = PH_DATA_OUT;
                  end else if (r.status_nibble == 4'hD || r.status_nibble == 4'hF) begin
                     eng_status = (r.status_nibble == 4'hF);
                     put_act(ACT_CTRL, 8'h04, ERR_NONE);
                     put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
                     eng_phase = PH_NIB_HI;
                  end else begin
                     eng_phase = PH_IDLE;
                     put_act(ACT_FINISHED, 8'hFF, ERR_BAD_PHASE);
                  end
               end
               PH_NIB_HI: begin
                  eng_hi = r.status_nibble;
                  put_act(ACT_CTRL, 8'h06, ERR_NONE);
                  put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
                  eng_phase = PH_NIB_LO;
               end
               PH_NIB_LO: begin
                  if (!eng_status) begin
                     put_act(ACT_BYTE_IN, {eng_hi, r.status_nibble}, ERR_NONE);
                     put_act(ACT_CTRL, 8'h0C, ERR_NONE);
                     put_act(ACT_SAMPLE, 8'h00, ERR_NONE);
                     eng_phase = PH_BUS_WAIT;
                     eng_wait  = 16'd0;
                  end else begin
                     put_act(ACT_CTRL, 8'h0E, ERR_NONE);
                     put_act(ACT_CTRL, 8'h0C, ERR_NONE);
                     put_pulse(8'h00, 1'b1);
                     put_pulse(8'h3C, 1'b1);
                     put_pulse(8'h20, 1'b1);
                     put_pulse(8'h0F, 1'b1);
                     put_act(ACT_FINISHED, {eng_hi, r.status_nibble}, ERR_NONE);
                     eng_phase = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
      endcase
      if (run_buf.size() > 0) begin
         t = run_buf[run_buf.size() - 1];
         t.last = 1'b1;
         run_buf[run_buf.size() - 1] = t;
      end
   endfunction

   function automatic row_type item_row(mode_type m, logic [2:0] tgt, logic [3:0] len,
                                        logic [7:0] hb, logic [3:0] nib);
      row_type row;
      row.kind                 = ROW_ITEM;
      row.req.mode             = m;
      row.req.target           = tgt;
      row.req.command_length   = len;
      row.req.host_byte        = hb;
      row.req.status_nibble    = nib;
      row.want                 = '0;
      row.id                   = 3'd0;
      row.limit                = 16'd0;
      return row;
   endfunction

   function automatic row_type typed_row(logic [3:0] nib, act_type a, logic [7:0] v, err_type e);
      row_type row;
      row = item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, nib);
      row.kind            = ROW_TYPED;
      row.want.action     = a;
      row.want.value      = v;
      row.want.error_kind = e;
      row.want.last       = 1'b1;
      return row;
   endfunction

   function automatic row_type cfg_row(logic [2:0] id, logic [15:0] limit);
      row_type row;
      row = item_row(MODE_START, 3'd0, 4'd0, 8'h00, 4'h0);
      row.kind  = ROW_CFG;
      row.id    = id;
      row.limit = limit;
      return row;
   endfunction

   // pick the next item from where the engine stands, with some noise
   function automatic req_type next_req();
      req_type r;
      int      pick;
      r.mode           = 2'($urandom_range(0, 3));
      r.target         = 3'($urandom_range(0, 7));
      r.command_length = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 3));
      r.host_byte      = 8'($urandom_range(0, 255));
      r.status_nibble  = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 8) return r;
      pick = $urandom_range(0, 99);
      case (eng_phase)
         PH_IDLE:     r.mode = MODE_START;
         PH_CMD_BYTE: r.mode = MODE_CMD;
         PH_DATA_OUT: r.mode = MODE_DATA;
         PH_SELECT: begin
            r.mode = MODE_SAMPLE;
            if (pick < 30) r.status_nibble = 4'h0;
         end
         PH_CMD_READY: begin
            r.mode = MODE_SAMPLE;
            r.status_nibble[3] = (pick >= 25);
         end
         PH_BUS_WAIT: begin
            r.mode = MODE_SAMPLE;
            if (pick < 20)      r.status_nibble[3] = 1'b0;
            else if (pick < 45) r.status_nibble = 4'hC;
            else if (pick < 75) r.status_nibble = 4'hD;
            else if (pick < 90) r.status_nibble = 4'hF;
            else if (pick < 98) r.status_nibble = 4'h8 + 4'($urandom_range(0, 3));
            else                r.status_nibble = 4'hE;
         end
         default: r.mode = MODE_SAMPLE;
      endcase
      return r;
   endfunction

   task automatic send_req(input req_type r, input bit typed, input rsp_type want,
                           output int produced);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_port_actions(r);
      produced = run_buf.size();
      if (typed) pending_actions.push_back(want);
      else foreach (run_buf[i]) pending_actions.push_back(run_buf[i]);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [2:0] id, input logic [15:0] limit);
      csr_write <= 1'b1;
      csr_index <= CSR_INITIATOR_ID;
      csr_wdata <= {13'd0, id};
      @(posedge clock);
      cfg_id = id;
      csr_index <= CSR_TIMEOUT_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      cfg_limit = limit;
      csr_write <= 1'b0;
   endtask

   // response side: check each transfer, then draw a stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (pending_actions.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected transfer: act %0d val %h err %0d last %0d",
                        rsp_data.action, rsp_data.value, rsp_data.error_kind, rsp_data.last);
            mismatches++;
         end else begin
            oldest = pending_actions.pop_front();
            if (rsp_data.action != oldest.action || rsp_data.value != oldest.value ||
                rsp_data.error_kind != oldest.error_kind || rsp_data.last != oldest.last) begin
               if (mismatches < 10)
                  $display({"expected act %0d val %h err %0d last %0d, ",
                            "got act %0d val %h err %0d last %0d"},
                           oldest.action, oldest.value, oldest.error_kind, oldest.last,
                           rsp_data.action, rsp_data.value, rsp_data.error_kind, rsp_data.last);
               mismatches++;
            end
         end
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_draw = $urandom_range(0, 5);
            rsp_hold  <= (rsp_draw != 0) ? rsp_draw - 1 : 0;
            rsp_stall <= (rsp_draw != 0);
         end
      end else if (rsp_stall) begin
         if (rsp_hold == 0) rsp_stall <= 1'b0;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int      produced;
      int      counted;
      int      next_cfg;
      int      pick;
      logic [15:0] limit;
      req_type r;

      reset      = 1'b1;
      csr_write  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_valid  = 1'b0;
      req_data   = '0;
      quiet      = 1'b0;
      eng_phase  = PH_IDLE;
      eng_wait   = 16'd0;
      eng_left   = 4'd0;
      eng_hi     = 4'd0;
      eng_status = 1'b0;
      cfg_id     = 3'd7;
      cfg_limit  = 16'd50000;

      // reset defaults, ignored items, a full write and read run, then a bad phase
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'hF));
      plan.push_back(item_row(MODE_CMD, 3'd0, 4'd0, 8'hFF, 4'h0));
      plan.push_back(item_row(MODE_DATA, 3'd0, 4'd0, 8'hFF, 4'h0));
      plan.push_back(item_row(MODE_START, 3'd0, 4'd0, 8'h00, 4'h0));
      plan.push_back(typed_row(4'h0, ACT_SAMPLE, 8'h00, ERR_NONE));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'h1));
      plan.push_back(typed_row(4'h7, ACT_SAMPLE, 8'h00, ERR_NONE));
      plan.push_back(typed_row(4'hC, ACT_NEED_DATA, 8'h00, ERR_NONE));
      plan.push_back(item_row(MODE_CMD, 3'd0, 4'd0, 8'h55, 4'hC));
      plan.push_back(item_row(MODE_DATA, 3'd0, 4'd0, 8'hFF, 4'h0));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'hD));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'hA));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'h5));
      plan.push_back(typed_row(4'h9, ACT_FINISHED, 8'hFF, ERR_BAD_PHASE));
      plan.push_back(item_row(MODE_START, 3'd7, 4'hF, 8'hFF, 4'hF));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'h8));
      plan.push_back(typed_row(4'h8, ACT_NEED_CMD, 8'h00, ERR_NONE));
      plan.push_back(item_row(MODE_CMD, 3'd0, 4'd0, 8'h00, 4'h0));
      // start abandoning the run in progress
      plan.push_back(item_row(MODE_START, 3'd3, 4'd1, 8'h00, 4'h0));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'hF));
      plan.push_back(typed_row(4'hF, ACT_NEED_CMD, 8'h00, ERR_NONE));
      plan.push_back(item_row(MODE_CMD, 3'd0, 4'd0, 8'hFF, 4'h0));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'hF));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'h0));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'hF));
      // zero limit: every wait fails on its first failing sample
      plan.push_back(cfg_row(3'd0, 16'd0));
      plan.push_back(item_row(MODE_START, 3'd5, 4'd2, 8'h00, 4'h0));
      plan.push_back(typed_row(4'h0, ACT_FINISHED, 8'hFF, ERR_SEL_TIMER));
      plan.push_back(item_row(MODE_START, 3'd1, 4'd1, 8'h00, 4'h0));
      plan.push_back(item_row(MODE_SAMPLE, 3'd0, 4'd0, 8'h00, 4'h8));
      plan.push_back(typed_row(4'h0, ACT_FINISHED, 8'hFF, ERR_RDY_TIMER));
      plan.push_back(cfg_row(3'd7, 16'hFFFF));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            wait_idle();
            write_cfg(plan[i].id, plan[i].limit);
         end else begin
            send_req(plan[i].req, plan[i].kind == ROW_TYPED, plan[i].want, produced);
         end
      end

      counted  = 0;
      next_cfg = 0;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= next_cfg) begin
            wait_idle();
            pick = $urandom_range(0, 5);
            if (pick == 0)      limit = 16'd0;
            else if (pick == 1) limit = 16'hFFFF;
            else if (pick == 2) limit = 16'd1;
            else                limit = 16'($urandom_range(0, 6));
            write_cfg(3'($urandom_range(0, 7)), limit);
            next_cfg = next_cfg + CFG_EVERY;
         end
         // a stretch without idling on either side
         quiet = (counted % 100) >= 80;
         r = next_req();
         send_req(r, 1'b0, '0, produced);
         if (produced > 0) counted++;
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
